@@ design/bccd_pkg.sv @@
// ----------------------------------------------------------------------------
// bccd_pkg
// shared types of the button click gesture detector
// ----------------------------------------------------------------------------
package bccd_pkg;

  // one result: single-tick event flags plus the long press level
  typedef struct packed {
    logic click;
    logic double_click;
    logic long_start;
    logic hold;
    logic long_release;
    logic pressed;
  } bccd_events_t;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

endpackage

@@ design/button_click_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// button_click_gesture_detector
// click, double click and long press recognition on polled button samples
// ----------------------------------------------------------------------------
// usage:
// - input channel: one transaction per poll tick, carrying the sampled button
//   level and a free-running timestamp; elapsed times wrap at TIME_BITS bits
//   (timestamps and thresholds are zero-extended or cut to that width)
// - result channel: exactly one transaction per input transaction, with the
//   event flags for that tick and the long press level flag
// - config port: cfg_we writes cfg_wdata into register cfg_index at once
//   (0 debounce, 1 long press, 2 click window, 3 double click enable);
//   write only while no transaction is in flight
// - path: an accepted input passes the input register, then the result register,
//   and is on the result channel while it sits in the result register
// - throughput: one transaction per cycle unless the result channel stalls,
//   set by the state update between the input register and the result register
// - stall: a stalled result holds in the result register while the input
//   register still takes one more transaction; in_stall rises after that
// - reset: state idle, timestamps and config cleared, both stages empty
// ----------------------------------------------------------------------------
module button_click_gesture_detector
  import bccd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_button_level,
  input  logic [31:0]               in_time_now,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_click_event,
  output logic                      out_double_click_event,
  output logic                      out_long_start_event,
  output logic                      out_hold_event,
  output logic                      out_long_release_event,
  output logic                      out_pressed_flag
);

  // width of stored timestamps, thresholds and elapsed-time differences
  localparam int TW = TIME_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLICK_WIN  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DC_ENABLE  = 2'd3;

  // config registers
  logic [TW-1:0] debounce_r, long_press_r, click_window_r;
  logic          dc_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= '0;
      long_press_r   <= '0;
      click_window_r <= '0;
      dc_enable_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r     <= TW'(cfg_wdata);
        REG_LONG_PRESS: long_press_r   <= TW'(cfg_wdata);
        REG_CLICK_WIN:  click_window_r <= TW'(cfg_wdata);
        REG_DC_ENABLE:  dc_enable_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // stage control
  logic in_valid_r, out_valid_r;
  logic out_free, move;

  assign out_free = !out_valid_r || !out_stall;  // result register can load
  assign move     = in_valid_r && out_free;      // tick goes through the fsm
  assign in_stall = in_valid_r && !out_free;

  // input register
  logic          in_level_r;
  logic [TW-1:0] in_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_level_r <= in_button_level;
      in_time_r  <= TW'(in_time_now);
    end
  end

  // gesture state machine
  bccd_events_t events_nxt, events_r;

  bccd_core #(
    .TW (TW)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (move),
    .level        (in_level_r),
    .now          (in_time_r),
    .debounce     (debounce_r),
    .long_press   (long_press_r),
    .click_window (click_window_r),
    .dc_enable    (dc_enable_r),
    .events       (events_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      events_r <= events_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_click_event        = events_r.click;
  assign out_double_click_event = events_r.double_click;
  assign out_long_start_event   = events_r.long_start;
  assign out_hold_event         = events_r.hold;
  assign out_long_release_event = events_r.long_release;
  assign out_pressed_flag       = events_r.pressed;

endmodule

@@ design/bccd_core.sv @@
// ----------------------------------------------------------------------------
// bccd_core
// gesture state machine with press and release timestamps
// ----------------------------------------------------------------------------
module bccd_core
  import bccd_pkg::*;
#(
  parameter int TW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          level,
  input  logic [TW-1:0] now,
  input  logic [TW-1:0] debounce,
  input  logic [TW-1:0] long_press,
  input  logic [TW-1:0] click_window,
  input  logic          dc_enable,
  output bccd_events_t  events
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DOWN  = 3'd1;
  localparam logic [2:0] ST_UP    = 3'd2;
  localparam logic [2:0] ST_DOWN2 = 3'd3;
  localparam logic [2:0] ST_LONG  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [TW-1:0] start_r, start_nxt;
  logic [TW-1:0] release_r, release_nxt;
  logic          long_r, long_nxt;
  logic [TW-1:0] el_start, el_release;

  // wrapping differences
  assign el_start   = now - start_r;
  assign el_release = now - release_r;

  always_comb begin
    state_nxt   = state_r;
    start_nxt   = start_r;
    release_nxt = release_r;
    long_nxt    = long_r;
    events      = '0;
    case (state_r)
      ST_DOWN: begin
        if (!level) begin
          if (el_start < debounce) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt   = ST_UP;
            release_nxt = now;
          end
        end else if (el_start > long_press) begin
          long_nxt          = 1'b1;
          events.long_start = 1'b1;
          events.hold       = 1'b1;
          state_nxt         = ST_LONG;
        end
      end
      ST_UP: begin
        if (!dc_enable || el_start > click_window) begin
          events.click = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (level && el_release > debounce) begin
          state_nxt = ST_DOWN2;
          start_nxt = now;
        end
      end
      ST_DOWN2: begin
        // an early release keeps waiting here
        if (!level && el_start > debounce) begin
          events.double_click = dc_enable;
          state_nxt           = ST_IDLE;
        end
      end
      ST_LONG: begin
        if (!level) begin
          long_nxt            = 1'b0;
          events.long_release = 1'b1;
          state_nxt           = ST_IDLE;
        end else begin
          long_nxt    = 1'b1;
          events.hold = 1'b1;
        end
      end
      default: begin
        // idle and unused codes
        if (level) begin
          state_nxt = ST_DOWN;
          start_nxt = now;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
    events.pressed = long_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_r   <= '0;
      release_r <= '0;
      long_r    <= 1'b0;
    end else if (step) begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      release_r <= release_nxt;
      long_r    <= long_nxt;
    end
  end

endmodule

@@ design/bccd_checker.sv @@
// ----------------------------------------------------------------------------
// bccd_checker
// port-level checks of the button click gesture detector
// ----------------------------------------------------------------------------
module bccd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_click_event,
  input logic out_double_click_event,
  input logic out_long_start_event,
  input logic out_hold_event,
  input logic out_long_release_event,
  input logic out_pressed_flag
);

  // stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result payload stays put
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_click_event, out_double_click_event,
      out_long_start_event, out_hold_event, out_long_release_event,
      out_pressed_flag}))
    else $error("result payload changed while stalled");

  // an accepted tick is followed by a valid result after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("no result two cycles after accepted tick");

  // long start and hold only while the long press is active
  a_long_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_long_start_event || out_hold_event) |-> out_pressed_flag)
    else $error("long press event without pressed flag");

endmodule

bind button_click_gesture_detector bccd_checker u_bccd_checker (.*);

@@ bench/tb_button_click_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// tb_button_click_gesture_detector
// self-checking bench for the button click gesture detector
// ----------------------------------------------------------------------------
// poll ticks go in through the valid/stall input channel, one event result per
// tick comes back. a scoreboard class keeps its own copy of the gesture state
// machine, predicts the events for every accepted tick and compares them with
// the results in order. a short directed part walks through click, bounce,
// double click, long press and the corner cases; random gesture sequences
// follow under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_button_click_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import bccd_pkg::*;

  localparam int CLK_PERIOD        = 10;
  localparam int RESET_CYCLES      = 7;
  localparam int REPORT_LIMIT      = 10;
  localparam int WATCHDOG_LIMIT    = 2000;
  // two stage pipeline with spare margin on top
  localparam int DRAIN_CYCLES      = 4;
  localparam int ITEMS_PER_SETTING = 78;

  // register map of the config port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEBOUNCE     = 0,
    REG_LONG_PRESS   = 1,
    REG_CLICK_WINDOW = 2,
    REG_DC_ENABLE    = 3
  } cfg_reg_e;

  // gesture states of the predicted machine
  typedef enum logic [2:0] {
    G_IDLE  = 3'd0,
    G_DOWN  = 3'd1,
    G_UP    = 3'd2,
    G_DOWN2 = 3'd3,
    G_LONG  = 3'd4
  } gesture_e;

  // --------------------------------------------------------------------------
  // event scoreboard: predicted gesture machine plus queue of expected events
  // --------------------------------------------------------------------------
  class gesture_scoreboard;
    logic [31:0]  debounce;
    logic [31:0]  long_press;
    logic [31:0]  click_window;
    bit           dc_enable;
    gesture_e     state;
    logic [31:0]  press_t;
    logic [31:0]  release_t;
    bit           long_on;
    bccd_events_t expected_q[$];
    int           failures;

    function new();
      debounce     = '0;
      long_press   = '0;
      click_window = '0;
      dc_enable    = 1'b0;
      state        = G_IDLE;
      press_t      = '0;
      release_t    = '0;
      long_on      = 1'b0;
      failures     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE:     debounce     = value;
        REG_LONG_PRESS:   long_press   = value;
        REG_CLICK_WINDOW: click_window = value;
        REG_DC_ENABLE:    dc_enable    = value[0];
        default: ;
      endcase
    endfunction

    // one accepted poll tick: advance the machine, queue the events it gives
    function void note_tick(bit level, logic [31:0] now);
      logic [31:0]  since_press;
      logic [31:0]  since_release;
      bccd_events_t ev;
      since_press   = now - press_t;
      since_release = now - release_t;
      ev = '0;
      case (state)
        G_DOWN: begin
          if (!level) begin
            if (since_press < debounce) begin
              state = G_IDLE;
            end else begin
              state     = G_UP;
              release_t = now;
            end
          end else if (since_press > long_press) begin
            long_on       = 1'b1;
            ev.long_start = 1'b1;
            ev.hold       = 1'b1;
            state         = G_LONG;
          end
        end
        G_UP: begin
          if (!dc_enable || since_press > click_window) begin
            ev.click = 1'b1;
            state    = G_IDLE;
          end else if (level && since_release > debounce) begin
            state   = G_DOWN2;
            press_t = now;
          end
        end
        G_DOWN2: begin
          // an early release is ignored, no timeout here
          if (!level && since_press > debounce) begin
            ev.double_click = dc_enable;
            state           = G_IDLE;
          end
        end
        G_LONG: begin
          if (!level) begin
            long_on         = 1'b0;
            ev.long_release = 1'b1;
            state           = G_IDLE;
          end else begin
            long_on = 1'b1;
            ev.hold = 1'b1;
          end
        end
        default: begin
          if (level) begin
            state   = G_DOWN;
            press_t = now;
          end else begin
            state = G_IDLE;
          end
        end
      endcase
      ev.pressed = long_on;
      expected_q.push_back(ev);
    endfunction

    // one accepted result against the oldest expectation
    function void check_result(bccd_events_t got);
      bccd_events_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: result with no tick waiting: %b", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: event mismatch (click dbl lstart hold lrel pressed)", $time);
          $display("  expected %b %b %b %b %b %b", want.click, want.double_click,
                   want.long_start, want.hold, want.long_release, want.pressed);
          $display("  actual   %b %b %b %b %b %b", got.click, got.double_click,
                   got.long_start, got.hold, got.long_release, got.pressed);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block signals
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  logic                      cfg_we;
  cfg_reg_e                  cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  logic                      in_valid;
  logic                      in_stall;
  logic                      in_button_level;
  logic [31:0]               in_time_now;

  logic                      out_valid;
  logic                      out_stall;
  logic                      out_click_event;
  logic                      out_double_click_event;
  logic                      out_long_start_event;
  logic                      out_hold_event;
  logic                      out_long_release_event;
  logic                      out_pressed_flag;

  bccd_events_t              out_events;

  gesture_scoreboard         sb;

  // stimulus knobs, changed between phases
  int unsigned               send_idle_pct;
  int unsigned               recv_stall_pct;
  int unsigned               step_max;
  logic [31:0]               stamp;
  int unsigned               items_sent;
  int unsigned               idle_cycles;

  button_click_gesture_detector #(
    .TIME_BITS(32)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_button_level        (in_button_level),
    .in_time_now            (in_time_now),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_click_event        (out_click_event),
    .out_double_click_event (out_double_click_event),
    .out_long_start_event   (out_long_start_event),
    .out_hold_event         (out_hold_event),
    .out_long_release_event (out_long_release_event),
    .out_pressed_flag       (out_pressed_flag)
  );

  assign out_events = '{
    click:        out_click_event,
    double_click: out_double_click_event,
    long_start:   out_long_start_event,
    hold:         out_hold_event,
    long_release: out_long_release_event,
    pressed:      out_pressed_flag
  };

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver side: random stall, updated on the falling edge only
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge, plus the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_tick(in_button_level, in_time_now);
      if (out_valid && !out_stall)
        sb.check_result(out_events);
      // no transaction on either side this cycle counts toward the timeout
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results pending", $time, sb.pending());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------

  // config write, only issued while nothing is in flight
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] deb, input logic [31:0] lng,
                           input logic [31:0] win, input logic [31:0] dce);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_CLICK_WINDOW, win);
    write_reg(REG_DC_ENABLE, dce);
  endtask

  // one poll tick transaction; random idle cycles in front of it
  task automatic send_tick(input bit level, input logic [31:0] now);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= level;
    in_time_now     <= now;
    // payload holds until the transaction is taken
    @(posedge clk);
    while (!(in_valid === 1'b1 && in_stall === 1'b0)) @(posedge clk);
  endtask

  // advance the timestamp by dt and send the level
  task automatic tick(input bit level, input logic [31:0] dt);
    stamp = stamp + dt;
    send_tick(level, stamp);
    items_sent++;
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly small time steps, now and then a jump anywhere on the timeline
  function automatic logic [31:0] next_step();
    if ($urandom_range(39) == 0)
      return $urandom();
    return $urandom_range(step_max);
  endfunction

  task automatic run_level(input bit level, input int unsigned n);
    repeat (n) tick(level, next_step());
  endtask

  // one random gesture: well-formed shapes with random timing, some noise
  task automatic run_gesture();
    step_max = $urandom_range(1, 8);
    case ($urandom_range(9))
      0, 1: begin
        // single click
        run_level(1'b1, $urandom_range(1, 4));
        run_level(1'b0, $urandom_range(1, 12));
      end
      2, 3, 4: begin
        // double click attempt, second release often early
        run_level(1'b1, $urandom_range(1, 3));
        run_level(1'b0, $urandom_range(1, 3));
        run_level(1'b1, $urandom_range(1, 3));
        run_level(1'b0, $urandom_range(1, 8));
      end
      5, 6: begin
        // long press with hold ticks
        run_level(1'b1, $urandom_range(5, 25));
        run_level(1'b0, $urandom_range(1, 4));
      end
      7: begin
        // contact bounce
        step_max = 1;
        run_level(1'b1, 1);
        run_level(1'b0, $urandom_range(1, 3));
      end
      default: begin
        // noise
        repeat ($urandom_range(1, 8)) tick(1'($urandom_range(1)), next_step());
      end
    endcase
  endtask

  // register value: mostly small, sometimes an extreme or full random
  function automatic logic [31:0] pick_reg(input int unsigned small_max);
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(small_max);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb              = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_DEBOUNCE;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_button_level = 1'b0;
    in_time_now     = '0;
    out_stall       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    step_max        = 1;
    stamp           = '0;
    items_sent      = 0;
    idle_cycles     = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, no idling ----
    write_all(32'd3, 32'd10, 32'd20, 32'd1);

    // timestamp extremes, press start at all ones, release after wrap
    tick(1'b0, 32'd0);
    tick(1'b1, 32'hFFFF_FFFF);
    tick(1'b0, 32'd4);
    // click window runs out in up
    tick(1'b0, 32'd30);

    // bounce shorter than debounce goes back to idle quietly
    tick(1'b1, 32'd1);
    tick(1'b0, 32'd1);

    // double click: gap too short first, then early second release ignored
    tick(1'b1, 32'd2);
    tick(1'b0, 32'd3);
    tick(1'b1, 32'd2);
    tick(1'b1, 32'd2);
    tick(1'b0, 32'd1);
    tick(1'b0, 32'd5);

    // long press: start, hold, release
    tick(1'b1, 32'd2);
    tick(1'b1, 32'd11);
    tick(1'b1, 32'd1);
    tick(1'b0, 32'd1);

    // double click off: click reported at once from up
    drain_pipeline();
    write_reg(REG_DC_ENABLE, 32'd0);
    tick(1'b1, 32'd1);
    tick(1'b0, 32'd5);
    tick(1'b1, 32'd0);

    // double click disabled while waiting in second down
    drain_pipeline();
    write_reg(REG_DC_ENABLE, 32'd1);
    tick(1'b1, 32'd1);
    tick(1'b0, 32'd4);
    tick(1'b1, 32'd4);
    drain_pipeline();
    write_reg(REG_DC_ENABLE, 32'd0);
    tick(1'b0, 32'd5);

    // all zero thresholds: long press after one unit of time
    drain_pipeline();
    write_all(32'd0, 32'd0, 32'd0, 32'd1);
    tick(1'b1, 32'd1);
    tick(1'b1, 32'd0);
    tick(1'b1, 32'd1);
    tick(1'b0, 32'd0);

    // ---- random part: four idle/stall mixes, two settings each ----
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int set = 0; set < 2; set++) begin
        int unsigned start_count;
        drain_pipeline();
        if (mode == 1 && set == 1) begin
          // everything at the top of its range
          write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end else if (mode == 2 && set == 1) begin
          write_all(32'd0, 32'd0, 32'd0, 32'd0);
        end else begin
          // enable word carries random upper bits, only bit 0 matters
          write_all(pick_reg(8), pick_reg(60), pick_reg(60), $urandom());
        end
        start_count = items_sent;
        while (items_sent - start_count < ITEMS_PER_SETTING) run_gesture();
      end
    end

    drain_pipeline();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
